>>> sv/ple_pkg.sv
// ============================================================================
// ple_pkg: shared types and constants of the positional list engine
// Holds the list depth, derived widths, operation codes and status codes.
// ============================================================================
`default_nettype none

package ple_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_FRONT = 3'd0,
    FN_ADD_REAR  = 3'd1,
    FN_DEL_FRONT = 3'd2,
    FN_DEL_REAR  = 3'd3,
    FN_INS_AT    = 3'd4,
    FN_DEL_AT    = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

`default_nettype wire

>>> sv/positional_list_engine_unit.sv
// ============================================================================
// positional_list_engine_unit: bounded list with positional insert and delete
// Keeps up to DEPTH signed words in a single-port-write memory and moves
// entries one at a time under a small sequencer.
// ============================================================================
// One request enters at a time and gives one result. A refused or ignored
// request moves no entries. For an insert or a delete, every entry behind
// the position is moved by one read and one write of the entry memory, which
// has one read and one write port, so the entries move one at a time. The
// result waits in an output register; the next request is taken as soon as
// the sequencer is idle.
`default_nettype none

module positional_list_engine_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [ple_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [ple_pkg::POS_W-1:0]   position_i,
  input  wire logic signed [ple_pkg::DATA_W-1:0] value_in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic signed [ple_pkg::DATA_W-1:0] removed_value_o,
  output      logic [1:0]                  status_o,
  output      logic [ple_pkg::COUNT_W-1:0] count_now_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GET  = 7'b0000010,
    S_CAP  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_WR   = 7'b0010000,
    S_PUT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ple_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ple_pkg::ADDR_W-1:0] k_q, k_d;
  logic [ple_pkg::ADDR_W-1:0] at_q, at_d;
  logic [ple_pkg::ADDR_W-1:0] lim_q, lim_d;
  logic                       ins_q, ins_d;
  logic [ple_pkg::DATA_W-1:0] val_q, val_d;
  logic [ple_pkg::DATA_W-1:0] rem_q, rem_d;
  ple_pkg::status_e           stat_q, stat_d;

  logic                        out_valid_q, out_valid_d;
  logic [ple_pkg::DATA_W-1:0]  out_rem_q, out_rem_d;
  logic [1:0]                  out_stat_q, out_stat_d;
  logic [ple_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;

  // entry memory
  logic [ple_pkg::DATA_W-1:0] mem [ple_pkg::DEPTH];
  logic [ple_pkg::DATA_W-1:0] rd_data_q;
  logic [ple_pkg::ADDR_W-1:0] rd_addr;
  logic [ple_pkg::ADDR_W-1:0] wr_addr;
  logic [ple_pkg::DATA_W-1:0] wr_data;
  logic                       wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // request decode
  logic                       full;
  logic [ple_pkg::CMP_W-1:0]  pos_x;
  logic [ple_pkg::CMP_W-1:0]  cnt_x;
  logic [ple_pkg::ADDR_W-1:0] cnt_a;
  logic [ple_pkg::ADDR_W-1:0] pos_a;

  assign full  = (count_q == ple_pkg::CNT_W'(ple_pkg::DEPTH));
  assign pos_x = ple_pkg::CMP_W'(position_i);
  assign cnt_x = ple_pkg::CMP_W'(count_q);
  assign cnt_a = count_q[ple_pkg::ADDR_W-1:0];
  assign pos_a = ple_pkg::ADDR_W'(position_i - ple_pkg::POS_W'(1));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    at_d        = at_q;
    lim_d       = lim_q;
    ins_d       = ins_q;
    val_d       = val_q;
    rem_d       = rem_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rem_d   = out_rem_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    rd_addr     = ins_q ? (k_q - ple_pkg::ADDR_W'(1)) : (k_q + ple_pkg::ADDR_W'(1));
    wr_en       = 1'b0;
    wr_addr     = k_q;
    wr_data     = rd_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d  = value_in_i;
          rem_d  = '0;
          stat_d = ple_pkg::ST_OK;
          state_d = S_DONE;
          case (func_i)
            ple_pkg::FN_ADD_FRONT, ple_pkg::FN_ADD_REAR, ple_pkg::FN_INS_AT: begin
              ins_d = 1'b1;
              k_d   = cnt_a;
              if (func_i == ple_pkg::FN_ADD_FRONT) begin
                at_d = '0;
              end else if (func_i == ple_pkg::FN_ADD_REAR) begin
                at_d = cnt_a;
              end else begin
                at_d = pos_a;
              end
              if (full) begin
                stat_d = ple_pkg::ST_FULL;
              end else if (func_i == ple_pkg::FN_INS_AT &&
                           (pos_x == '0 || pos_x > cnt_x + ple_pkg::CMP_W'(1))) begin
                stat_d = ple_pkg::ST_RANGE;
              end else if (k_d == at_d) begin
                state_d = S_PUT;
              end else begin
                state_d = S_RD;
              end
            end
            ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_REAR, ple_pkg::FN_DEL_AT: begin
              ins_d = 1'b0;
              lim_d = ple_pkg::ADDR_W'(count_q - ple_pkg::CNT_W'(1));
              if (func_i == ple_pkg::FN_DEL_FRONT) begin
                at_d = '0;
              end else if (func_i == ple_pkg::FN_DEL_REAR) begin
                at_d = lim_d;
              end else begin
                at_d = pos_a;
              end
              k_d = at_d;
              if (func_i == ple_pkg::FN_DEL_AT) begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                  stat_d = ple_pkg::ST_RANGE;
                end else begin
                  state_d = S_GET;
                end
              end else if (count_q == '0) begin
                stat_d = ple_pkg::ST_UNDER;
              end else begin
                state_d = S_GET;
              end
            end
            default: begin
              // unused codes: report ok and change nothing
            end
          endcase
        end
      end
      S_GET: begin
        rd_addr = at_q;
        state_d = S_CAP;
      end
      S_CAP: begin
        rem_d   = rd_data_q;
        count_d = count_q - ple_pkg::CNT_W'(1);
        state_d = (at_q < lim_q) ? S_RD : S_DONE;
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        // move one entry by one place toward the gap
        wr_en = 1'b1;
        if (ins_q) begin
          k_d     = k_q - ple_pkg::ADDR_W'(1);
          state_d = (k_d == at_q) ? S_PUT : S_RD;
        end else begin
          k_d     = k_q + ple_pkg::ADDR_W'(1);
          state_d = (k_d < lim_q) ? S_RD : S_DONE;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = at_q;
        wr_data = val_q;
        count_d = count_q + ple_pkg::CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rem_d   = rem_q;
          out_stat_d  = stat_q;
          out_cnt_d   = ple_pkg::COUNT_W'(count_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    at_q       <= at_d;
    lim_q      <= lim_d;
    ins_q      <= ins_d;
    val_q      <= val_d;
    rem_q      <= rem_d;
    stat_q     <= stat_d;
    out_rem_q  <= out_rem_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_rem_q;
  assign status_o        = out_stat_q;
  assign count_now_o     = out_cnt_q;

endmodule

`default_nettype wire

>>> sv/ple_checker.sv
// ============================================================================
// ple_checker: port-level checks of the positional list engine
// Watches the result channel and the status it reports over time.
// ============================================================================
`default_nettype none

module ple_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [ple_pkg::DATA_W-1:0]  removed_value_o,
  input wire logic [1:0]                  status_o,
  input wire logic [ple_pkg::COUNT_W-1:0] count_now_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(removed_value_o) &&
      $stable(status_o) && $stable(count_now_o))
    else $error("result changed while stalled");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ple_pkg::ST_OK |-> removed_value_o == '0)
    else $error("refused transaction returned a value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_now_o <= ple_pkg::COUNT_W'(ple_pkg::DEPTH))
    else $error("count beyond depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ple_pkg::ST_FULL |->
      count_now_o == ple_pkg::COUNT_W'(ple_pkg::DEPTH))
    else $error("full status with list not full");

  a_under_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ple_pkg::ST_UNDER |-> count_now_o == '0)
    else $error("underflow status with list not empty");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .removed_value_o (removed_value_o),
  .status_o        (status_o),
  .count_now_o     (count_now_o)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: random and directed test of positional_list_engine_unit
// Pushes list requests through the valid/ready input channel, predicts every
// outcome with a shadow list kept in a queue, and checks each result in order.
// Both channels idle in bursts; the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [ple_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [ple_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS  = 1750;
  localparam int CALM_TAIL     = 150;
  localparam int HOLD_LEN      = 300;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 3000;

  typedef struct {
    logic [ple_pkg::FUNC_W-1:0]        func;
    logic [ple_pkg::POS_W-1:0]         pos;
    logic signed [ple_pkg::DATA_W-1:0] val;
    bit                                drain;
  } request_t;

  typedef struct {
    logic signed [ple_pkg::DATA_W-1:0] removed;
    ple_pkg::status_e                  status;
    logic [ple_pkg::COUNT_W-1:0]       count;
  } outcome_t;

  logic                              clk_i      = 1'b0;
  logic                              rst_ni     = 1'b0;
  logic                              in_valid   = 1'b0;
  logic                              in_ready;
  logic [ple_pkg::FUNC_W-1:0]        func       = '0;
  logic [ple_pkg::POS_W-1:0]         position   = '0;
  logic signed [ple_pkg::DATA_W-1:0] value_in   = '0;
  logic                              out_valid;
  logic                              out_ready  = 1'b0;
  logic signed [ple_pkg::DATA_W-1:0] removed_value;
  logic [1:0]                        status;
  logic [ple_pkg::COUNT_W-1:0]       count_now;

  request_t                          request_q[$];
  outcome_t                          result_due_q[$];
  logic signed [ple_pkg::DATA_W-1:0] shadow_list[$];

  int n_items     = 0;
  int gen_count   = 0;
  int random_cnt  = 0;
  int in_seen     = 0;
  int out_seen    = 0;
  int errors      = 0;

  positional_list_engine_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .position_i      (position),
    .value_in_i      (value_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .removed_value_o (removed_value),
    .status_o        (status),
    .count_now_o     (count_now)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the shadow list and return the outcome it should give.
  function automatic outcome_t list_apply(logic [ple_pkg::FUNC_W-1:0] f,
                                          logic [ple_pkg::POS_W-1:0] p,
                                          logic signed [ple_pkg::DATA_W-1:0] v);
    outcome_t o;
    int       n;
    o.removed = '0;
    o.status  = ple_pkg::ST_OK;
    n = shadow_list.size();
    case (f)
      ple_pkg::FN_ADD_FRONT: begin
        if (n >= ple_pkg::DEPTH) o.status = ple_pkg::ST_FULL;
        else shadow_list.push_front(v);
      end
      ple_pkg::FN_ADD_REAR: begin
        if (n >= ple_pkg::DEPTH) o.status = ple_pkg::ST_FULL;
        else shadow_list.push_back(v);
      end
      ple_pkg::FN_DEL_FRONT: begin
        if (n == 0) o.status = ple_pkg::ST_UNDER;
        else o.removed = shadow_list.pop_front();
      end
      ple_pkg::FN_DEL_REAR: begin
        if (n == 0) o.status = ple_pkg::ST_UNDER;
        else o.removed = shadow_list.pop_back();
      end
      ple_pkg::FN_INS_AT: begin
        if (n >= ple_pkg::DEPTH) o.status = ple_pkg::ST_FULL;
        else if (p < 1 || p > n + 1) o.status = ple_pkg::ST_RANGE;
        else shadow_list.insert(p - 1, v);
      end
      ple_pkg::FN_DEL_AT: begin
        if (p < 1 || p > n) o.status = ple_pkg::ST_RANGE;
        else begin
          o.removed = shadow_list[p - 1];
          shadow_list.delete(p - 1);
        end
      end
      default: ;
    endcase
    o.count = ple_pkg::COUNT_W'(shadow_list.size());
    return o;
  endfunction

  // Queue a request and track the list length so later positions can aim at it.
  task automatic queue_request(logic [ple_pkg::FUNC_W-1:0] f,
                               logic [ple_pkg::POS_W-1:0] p,
                               logic signed [ple_pkg::DATA_W-1:0] v, bit drain);
    request_t r;
    r.func  = f;
    r.pos   = p;
    r.val   = v;
    r.drain = drain;
    request_q.push_back(r);
    case (f)
      ple_pkg::FN_ADD_FRONT, ple_pkg::FN_ADD_REAR:
        if (gen_count < ple_pkg::DEPTH) gen_count++;
      ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_REAR:
        if (gen_count > 0) gen_count--;
      ple_pkg::FN_INS_AT:
        if (gen_count < ple_pkg::DEPTH && p >= 1 && p <= gen_count + 1) gen_count++;
      ple_pkg::FN_DEL_AT:
        if (p >= 1 && p <= gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic [ple_pkg::POS_W-1:0] pick_position(int hi);
    if (hi >= 1 && $urandom_range(0, 99) < 85)
      return ple_pkg::POS_W'($urandom_range(1, hi));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ple_pkg::POS_W'(hi + 1);
      2:       return '1;
      default: return ple_pkg::POS_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [ple_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // One random request, adds with probability add_pct; a spare opcode now and then.
  task automatic queue_random(int add_pct);
    logic [ple_pkg::FUNC_W-1:0] f;
    logic [ple_pkg::POS_W-1:0]  p;
    if ($urandom_range(0, 99) < 3) begin
      f = ($urandom_range(0, 1) == 0) ? FN_SPARE_6 : FN_SPARE_7;
      queue_request(f, ple_pkg::POS_W'($urandom_range(0, 127)), pick_value(), 1'b0);
    end
    if ($urandom_range(0, 99) < add_pct) begin
      case ($urandom_range(0, 2))
        0:       f = ple_pkg::FN_ADD_FRONT;
        1:       f = ple_pkg::FN_ADD_REAR;
        default: f = ple_pkg::FN_INS_AT;
      endcase
      p = pick_position(gen_count + 1);
    end else begin
      case ($urandom_range(0, 2))
        0:       f = ple_pkg::FN_DEL_FRONT;
        1:       f = ple_pkg::FN_DEL_REAR;
        default: f = ple_pkg::FN_DEL_AT;
      endcase
      p = pick_position(gen_count);
    end
    if (f != ple_pkg::FN_INS_AT && f != ple_pkg::FN_DEL_AT)
      p = ple_pkg::POS_W'($urandom_range(0, 127));
    // Pause the sender until every earlier result is back, at the start and halfway.
    queue_request(f, p, pick_value(), random_cnt == 0 || random_cnt == RANDOM_ITEMS / 2);
    random_cnt++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t ns: got %h, expected %h", what, $time, got, want);
    errors++;
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int phase;
    int kind;

    // Empty list corner cases.
    queue_request(ple_pkg::FN_DEL_FRONT, 7'd0,   32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_DEL_REAR,  7'd127, 32'hffff_ffff, 1'b0);
    queue_request(ple_pkg::FN_DEL_AT,    7'd1,   32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_DEL_AT,    7'd0,   32'h0000_0001, 1'b0);
    queue_request(ple_pkg::FN_INS_AT,    7'd0,   32'h0000_0005, 1'b0);
    queue_request(ple_pkg::FN_INS_AT,    7'd2,   32'h0000_0005, 1'b0);
    // Build a short list through every add path.
    queue_request(ple_pkg::FN_INS_AT,    7'd1,   32'h7fff_ffff, 1'b0);
    queue_request(ple_pkg::FN_ADD_FRONT, 7'h55,  32'h8000_0000, 1'b0);
    queue_request(ple_pkg::FN_ADD_REAR,  7'h2a,  32'hffff_ffff, 1'b0);
    queue_request(ple_pkg::FN_INS_AT,    7'd4,   32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_INS_AT,    7'd2,   32'h1234_5678, 1'b0);
    // Positions past the end and at the end, then the spare codes.
    queue_request(ple_pkg::FN_INS_AT,    7'd127, 32'h0000_0001, 1'b0);
    queue_request(ple_pkg::FN_DEL_AT,    7'd127, 32'h0000_0001, 1'b0);
    queue_request(ple_pkg::FN_DEL_AT,    7'd6,   32'h0000_0001, 1'b0);
    queue_request(ple_pkg::FN_DEL_AT,    7'd5,   32'h0000_0000, 1'b0);
    queue_request(FN_SPARE_6,            7'd3,   32'h0000_0003, 1'b0);
    queue_request(FN_SPARE_7,            7'd127, 32'hffff_ffff, 1'b0);
    // Drain through every delete path, then underflow again.
    queue_request(ple_pkg::FN_DEL_AT,    7'd2,   32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_DEL_FRONT, 7'd64,  32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_DEL_REAR,  7'd1,   32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_DEL_AT,    7'd1,   32'h0000_0000, 1'b0);
    queue_request(ple_pkg::FN_DEL_REAR,  7'd0,   32'h0000_0000, 1'b0);

    // Random part: fill to full, drain to empty, and mixed stretches between.
    phase = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      kind = (phase < 2) ? phase : $urandom_range(0, 5);
      case (kind)
        0: begin
          while (gen_count < ple_pkg::DEPTH) queue_random(100);
          repeat ($urandom_range(3, 8)) queue_random(100);
        end
        1: begin
          while (gen_count > 0) queue_random(0);
          repeat ($urandom_range(3, 8)) queue_random(0);
        end
        default: repeat ($urandom_range(20, 120)) queue_random(25 * $urandom_range(1, 3));
      endcase
      phase++;
    end
    n_items = request_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (in_seen != n_items || out_seen != in_seen);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (result_due_q.size() != 0) report_mismatch("results still due", result_due_q.size(), 0);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    int       sent_n;
    int       send_gap;
    request_t req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sent_n   = 0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) sent_n++;
      // Hold the payload until the transaction completes.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (request_q[0].drain && out_seen != sent_n) begin
          in_valid <= 1'b0;
        end else if (sent_n + CALM_TAIL < n_items && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          req = request_q.pop_front();
          in_valid <= 1'b1;
          func     <= req.func;
          position <= req.pos;
          value_in <= req.val;
        end
      end
    end
  end

  // Result receiver: random idle bursts plus two long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int hold_cnt;
    int hold_idx;
    int rdy_gap;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
      hold_idx = 0;
      rdy_gap  = 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if ((hold_idx == 0 && out_seen >= 400) || (hold_idx == 1 && out_seen >= 1100)) begin
      hold_idx++;
      hold_cnt = HOLD_LEN;
      out_ready <= 1'b0;
    end else if (out_seen + CALM_TAIL >= n_items) begin
      out_ready <= 1'b1;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rdy_gap = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on each accepted request, check each accepted result.
  always @(posedge clk_i) begin : monitor
    outcome_t due;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        result_due_q.push_back(list_apply(func, position, value_in));
        in_seen <= in_seen + 1;
      end
      if (out_valid && out_ready) begin
        out_seen <= out_seen + 1;
        if (result_due_q.size() == 0) begin
          report_mismatch("unexpected result", removed_value, 0);
        end else begin
          due = result_due_q.pop_front();
          if (removed_value !== due.removed)
            report_mismatch("removed_value", removed_value, due.removed);
          if (status !== due.status)
            report_mismatch("status", status, due.status);
          if (count_now !== due.count)
            report_mismatch("count_now", count_now, due.count);
        end
      end
    end
  end

  // Stop the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
